FILE: sv/zsi_pkg.sv
// Shared types, codes and constant tables for the zoom stop interpolator.
`default_nettype none
package zsi_pkg;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LOG2_BASE  = 1'b1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_INTERP = 2'd1;
  localparam logic [1:0] POS_BEYOND = 2'd2;

  localparam int EXP_STEPS = 23;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [16:0] ONE_Q16 = 17'h1_0000;

  typedef struct packed {
    logic               operation;
    logic [3:0]         stop_index;
    logic [15:0]        stop_zoom;
    logic signed [31:0] stop_value;
    logic [15:0]        query_zoom;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         position;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_CMP,
    S_YMUL,
    S_YCAP,
    S_EXPMUL,
    S_EXPCAP,
    S_EXPEND,
    S_DIVSTART,
    S_DIVWAIT,
    S_PMUL,
    S_PCAP,
    S_DONE
  } state_e;

  typedef logic [29:0] gtab_t [EXP_STEPS+1];

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v = v_in;
    res = '0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 64'd0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // g[k] = 2^(-2^-k) in Q0.30, each from a truncated square root of the last
  function automatic gtab_t gen_gtab();
    gtab_t t;
    logic [63:0] g;
    g = 64'h1 << 29;
    t[0] = 30'(g);
    for (int k = 1; k <= EXP_STEPS; k++) begin
      g = isqrt64(g << 30);
      t[k] = 30'(g);
    end
    return t;
  endfunction

endpackage
`default_nettype wire

FILE: sv/zsi_stop_mem.sv
// Stop table: zoom and value per stop, one write and one registered read port.
`default_nettype none
module zsi_stop_mem #(
  parameter int DEPTH = 16,
  parameter int AW = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AW-1:0]        waddr_i,
  input  wire logic [15:0]          wzoom_i,
  input  wire logic signed [31:0]   wvalue_i,
  input  wire logic [AW-1:0]        raddr_i,
  output logic [15:0]               rzoom_o,
  output logic signed [31:0]        rvalue_o
);

  logic [15:0]        zoom_mem [DEPTH];
  logic signed [31:0] value_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      zoom_mem[waddr_i]  <= wzoom_i;
      value_mem[waddr_i] <= wvalue_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rzoom_o  <= zoom_mem[raddr_i];
    rvalue_o <= value_mem[raddr_i];
  end

endmodule
`default_nettype wire

FILE: sv/zsi_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none
module zsi_mul (
  input  wire logic               clk_i,
  input  wire logic signed [33:0] a_i,
  input  wire logic signed [33:0] b_i,
  output logic signed [67:0]      prod_o
);

  always_ff @(posedge clk_i) begin
    prod_o <= a_i * b_i;
  end

endmodule
`default_nettype wire

FILE: sv/zsi_div.sv
// Restoring divider: 16 fraction bits of num/den, one bit per cycle, num < den.
`default_nettype none
module zsi_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [16:0] num_i,
  input  wire logic [16:0] den_i,
  output logic             done_o,
  output logic [15:0]      quot_o
);

  logic        busy_q;
  logic        done_q;
  logic [3:0]  cnt_q;
  logic [17:0] rem_q;
  logic [16:0] den_q;
  logic [15:0] quo_q;
  logic [17:0] rem2;
  logic        ge;

  assign rem2 = {rem_q[16:0], 1'b0};
  assign ge   = rem2 >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i};
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? rem2 - {1'b0, den_q} : rem2;
      quo_q <= {quo_q[14:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

FILE: sv/zoom_stop_interpolator.sv
// Zoom stop interpolator: stop table, segment search and exponential ratio sequencer.
//
// Holds up to MAX_STOPS (zoom, value) stops and evaluates one item at a time.
// A stop write is taken while idle. A query reads the first stop, then scans the
// stops in order through the search (one table read port); an interpolated result
// then takes the bit-serial divide plus the final multiply when log2_base is zero,
// or, when it is not, up to two 2^-x evaluations of 23 steps each on the single
// shared multiplier before the divide. The input stalls while a query is in work;
// one finished result may wait in the output register while the next item is taken.
`default_nettype none
module zoom_stop_interpolator
  import zsi_pkg::*;
#(
  parameter int MAX_STOPS = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_item_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_item_t                  out_data_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int IW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
  localparam int SAT_W = 50;
  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
  localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);
  localparam gtab_t GTAB = gen_gtab();

  state_e state_q, state_d;

  logic [4:0]         stop_count_q;
  logic signed [15:0] log2_base_q;

  logic               in_acc;
  logic               mem_we;
  logic [IW-1:0]      raddr;
  logic [15:0]        rd_zoom;
  logic signed [31:0] rd_value;

  logic [15:0]        query_q;
  logic [IW-1:0]      n_last_q, n_last_new, idx_q;
  int                 n_clamp;
  logic [15:0]        prev_z_q;
  logic signed [31:0] prev_v_q, va_q, vb_q;
  logic [15:0]        d_q, dd_q;
  logic               exp_sel_q;
  logic [31:0]        y_q;
  logic [30:0]        x_q;
  logic [4:0]         k_q;
  logic [16:0]        es_q, num_q, den_q;
  logic [15:0]        ratio_q;
  logic signed [34:0] res_q;
  logic [1:0]         pos_q;

  logic               seg_hit;
  logic               base_zero, base_pos;
  logic [15:0]        a_abs;
  logic [15:0]        y2;
  logic [8:0]         ip;
  logic [4:0]         shamt;
  logic [16:0]        e_val, den_new, num_new;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod;
  logic               div_start, div_done;
  logic [15:0]        div_quot;
  logic signed [34:0] qt;
  logic signed [SAT_W-1:0] res_ext;
  logic signed [31:0] res_sat;
  logic               out_free;
  logic               out_valid_q;
  out_item_t          out_data_q;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_count_q <= 5'd2;
      log2_base_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_STOP_COUNT: stop_count_q <= cfg_data_i[4:0];
        REG_LOG2_BASE:  log2_base_q  <= $signed(cfg_data_i[15:0]);
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign mem_we     = in_acc && (in_data_i.operation == OP_WRITE) &&
                      (int'(in_data_i.stop_index) < MAX_STOPS);

  always_comb begin
    n_clamp = int'(stop_count_q);
    if (n_clamp < 2) n_clamp = 2;
    if (n_clamp > MAX_STOPS) n_clamp = MAX_STOPS;
    n_last_new = IW'(n_clamp - 1);
  end

  always_comb begin
    case (state_q)
      S_IDLE:  raddr = '0;
      S_FIRST: raddr = IW'(1);
      S_CMP:   raddr = idx_q + IW'(1);
      default: raddr = idx_q;
    endcase
  end

  zsi_stop_mem #(
    .DEPTH(MAX_STOPS),
    .AW   (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (IW'(in_data_i.stop_index)),
    .wzoom_i (in_data_i.stop_zoom),
    .wvalue_i(in_data_i.stop_value),
    .raddr_i (raddr),
    .rzoom_o (rd_zoom),
    .rvalue_o(rd_value)
  );

  assign seg_hit   = (prev_z_q <= query_q) && (query_q < rd_zoom);
  assign base_zero = (log2_base_q == 16'sd0);
  assign base_pos  = !log2_base_q[15] && !base_zero;
  assign a_abs     = log2_base_q[15] ? 16'(-log2_base_q) : 16'(log2_base_q);
  assign y2        = base_pos ? dd_q - d_q : d_q;

  // 2^-y from the integer part shift and the Q1.30 fraction product
  assign ip      = y_q[31:23];
  assign shamt   = 5'd14 + ip[4:0];
  assign e_val   = (ip >= 9'd17) ? 17'd0 : 17'(x_q >> shamt);
  assign den_new = ONE_Q16 - e_val;
  assign num_new = base_pos ? ((e_val > es_q) ? e_val - es_q : 17'd0) : ONE_Q16 - e_val;

  always_comb begin
    case (state_q)
      S_YMUL: begin
        mul_a = {18'd0, (exp_sel_q ? y2 : dd_q)};
        mul_b = {18'd0, a_abs};
      end
      S_EXPMUL: begin
        mul_a = {3'd0, x_q};
        mul_b = {4'd0, GTAB[k_q]};
      end
      S_PMUL: begin
        mul_a = {18'd0, ratio_q};
        mul_b = 34'(vb_q) - 34'(va_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  zsi_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(prod)
  );

  assign div_start = (state_q == S_DIVSTART);

  zsi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num_q),
    .den_i  (den_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // floor of the product over 2^16
  assign qt = prod[50:16];

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && in_data_i.operation == OP_QUERY) state_d = S_FIRST;
      end
      S_FIRST: begin
        state_d = (query_q <= rd_zoom) ? S_DONE : S_CMP;
      end
      S_CMP: begin
        if (seg_hit) begin
          state_d = base_zero ? S_DIVSTART : S_YMUL;
        end else if (idx_q == n_last_q) begin
          state_d = S_DONE;
        end
      end
      S_YMUL:   state_d = S_YCAP;
      S_YCAP:   state_d = S_EXPMUL;
      S_EXPMUL: state_d = S_EXPCAP;
      S_EXPCAP: begin
        state_d = (k_q == 5'(EXP_STEPS)) ? S_EXPEND : S_EXPMUL;
      end
      S_EXPEND: begin
        if (!exp_sel_q) begin
          state_d = (den_new == 17'd0) ? S_DIVSTART : S_YMUL;
        end else begin
          state_d = (num_new >= den_q) ? S_PMUL : S_DIVSTART;
        end
      end
      S_DIVSTART: state_d = S_DIVWAIT;
      S_DIVWAIT: begin
        if (div_done) state_d = S_PMUL;
      end
      S_PMUL: state_d = S_PCAP;
      S_PCAP: state_d = S_DONE;
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          query_q  <= in_data_i.query_zoom;
          n_last_q <= n_last_new;
        end
      end
      S_FIRST: begin
        prev_z_q <= rd_zoom;
        prev_v_q <= rd_value;
        idx_q    <= IW'(1);
        res_q    <= 35'(rd_value);
        pos_q    <= POS_FIRST;
      end
      S_CMP: begin
        prev_z_q <= rd_zoom;
        prev_v_q <= rd_value;
        if (seg_hit) begin
          d_q       <= query_q - prev_z_q;
          dd_q      <= rd_zoom - prev_z_q;
          va_q      <= prev_v_q;
          vb_q      <= rd_value;
          num_q     <= {1'b0, query_q - prev_z_q};
          den_q     <= {1'b0, rd_zoom - prev_z_q};
          exp_sel_q <= 1'b0;
        end else begin
          idx_q <= idx_q + IW'(1);
          res_q <= 35'(rd_value);
          pos_q <= POS_BEYOND;
        end
      end
      S_YCAP: begin
        y_q <= prod[31:0];
        x_q <= ONE_Q30;
        k_q <= 5'd1;
      end
      S_EXPCAP: begin
        if (y_q[5'(5'(EXP_STEPS) - k_q)]) x_q <= prod[60:30];
        k_q <= k_q + 5'd1;
      end
      S_EXPEND: begin
        if (!exp_sel_q) begin
          es_q      <= e_val;
          exp_sel_q <= 1'b1;
          if (den_new == 17'd0) begin
            // base too close to one: fall back to the linear ratio
            num_q <= {1'b0, d_q};
            den_q <= {1'b0, dd_q};
          end else begin
            den_q <= den_new;
          end
        end else begin
          num_q   <= num_new;
          ratio_q <= 16'hFFFF;
        end
      end
      S_DIVWAIT: begin
        if (div_done) ratio_q <= div_quot;
      end
      S_PCAP: begin
        res_q <= 35'(va_q) + qt;
        pos_q <= POS_INTERP;
      end
      default: ;
    endcase
  end

  // saturate to VALUE_BITS, then keep the port width
  always_comb begin
    res_ext = SAT_W'(res_q);
    if (res_ext > SAT_HI) res_ext = SAT_HI;
    if (res_ext < SAT_LO) res_ext = SAT_LO;
    res_sat = res_ext[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      out_data_q.result_value <= res_sat;
      out_data_q.position     <= pos_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_div_operands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIVSTART |-> (den_q != 17'd0) && (num_q < den_q))
    else $error("divider started with operands outside its range");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMP |-> idx_q <= n_last_q)
    else $error("stop scan ran past the last stop in use");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIVWAIT)
    else $error("divider finished outside the wait state");

  a_exp_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXPMUL |-> (k_q >= 5'd1) && (k_q <= 5'(EXP_STEPS)))
    else $error("exp step counter out of range");

  a_pos_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.position == POS_FIRST) ||
                    (out_data_o.position == POS_INTERP) ||
                    (out_data_o.position == POS_BEYOND))
    else $error("result carries an unknown position code");

endmodule
`default_nettype wire

FILE: dv/tb_zoom_stop_interpolator.sv
// Testbench for zoom_stop_interpolator: stop table loads, queries, config phases, scoreboard.
module tb_zoom_stop_interpolator;
  import zsi_pkg::*;

  localparam int NSTOPS = 16;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT = 600000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  zoom_stop_interpolator u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [15:0]        zoom_tab [NSTOPS];
  logic signed [31:0] value_tab [NSTOPS];
  logic [4:0]         stops_used = 5'd2;
  logic signed [15:0] base_log2 = 16'sd0;
  logic [63:0]        root_step [24];

  out_item_t expected_q [$];
  int  mismatches = 0;
  int  cycles = 0;
  bit  calm = 1'b0;
  int  hold_req = 0;
  int  hold_seen = 0;
  int  hold_left = 0;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t result;
  } dir_row_t;

  dir_row_t dir_tab [$];

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // 2^-y with y in Q.23, result Q1.16
  function automatic logic [16:0] pow2_neg(input logic [63:0] y);
    logic [63:0] x;
    logic [63:0] ip;
    ip = y >> 23;
    if (ip >= 17) return '0;
    x = 64'd1 << 30;
    for (int k = 1; k <= 23; k++)
      if (y[23-k]) x = (x * root_step[k]) >> 30;
    return 17'(x >> (14 + ip));
  endfunction

  function automatic logic [31:0] lin_ratio(input logic [31:0] d, input logic [31:0] dd);
    return 32'((64'(d) << 16) / dd);
  endfunction

  function automatic logic [31:0] seg_ratio(input logic [31:0] d, input logic [31:0] dd);
    logic [63:0] a;
    logic [63:0] es;
    logic [63:0] den;
    longint num;
    logic [63:0] r;
    if (base_log2 == 0) return lin_ratio(d, dd);
    a = (base_log2 < 0) ? 64'(-int'(base_log2)) : 64'(int'(base_log2));
    es = 64'(pow2_neg(64'(dd) * a));
    den = 64'd65536 - es;
    if (den == 0) return lin_ratio(d, dd);
    if (base_log2 > 0) num = longint'(pow2_neg(64'(dd - d) * a)) - longint'(es);
    else num = 65536 - longint'(pow2_neg(64'(d) * a));
    if (num < 0) num = 0;
    r = (64'(num) << 16) / den;
    return (r > 65535) ? 32'd65535 : 32'(r);
  endfunction

  function automatic out_item_t evaluate_zoom(input logic [15:0] q);
    out_item_t o;
    int n;
    logic [31:0] r;
    longint va, vb, p, qt, s;
    n = stops_used;
    if (n < 2) n = 2;
    if (n > NSTOPS) n = NSTOPS;
    if (q <= zoom_tab[0]) begin
      o.result_value = value_tab[0];
      o.position = POS_FIRST;
      return o;
    end
    for (int i = 1; i < n; i++) begin
      if (zoom_tab[i-1] <= q && q < zoom_tab[i]) begin
        r = seg_ratio(32'(q - zoom_tab[i-1]), 32'(zoom_tab[i] - zoom_tab[i-1]));
        va = value_tab[i-1];
        vb = value_tab[i];
        p = longint'(r) * (vb - va);
        qt = (p >= 0) ? p / 65536 : -((-p + 65535) / 65536);
        s = va + qt;
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        o.result_value = 32'(s);
        o.position = POS_INTERP;
        return o;
      end
    end
    o.result_value = value_tab[n-1];
    o.position = POS_BEYOND;
    return o;
  endfunction

  task automatic report_mismatch(input string what);
    $display("tb: mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t te);
    if (!calm && $urandom_range(0, 99) < 10) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    if (it.operation == OP_WRITE) begin
      zoom_tab[it.stop_index] = it.stop_zoom;
      value_tab[it.stop_index] = it.stop_value;
    end else begin
      expected_q.insert(expected_q.size(), typed ? te : evaluate_zoom(it.query_zoom));
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_STOP_COUNT) stops_used = val[4:0];
    else base_log2 = val;
  endtask

  function automatic in_item_t rand_item(input logic op);
    in_item_t it;
    it.operation = op;
    it.stop_index = 4'($urandom);
    it.stop_zoom = 16'($urandom);
    it.stop_value = 32'($urandom);
    it.query_zoom = 16'($urandom);
    return it;
  endfunction

  // ascending stop table with random spacing, duplicates allowed
  task automatic load_sorted_table();
    in_item_t it;
    int z;
    int span;
    z = $urandom_range(0, 3000);
    for (int k = 0; k < NSTOPS; k++) begin
      it = rand_item(OP_WRITE);
      it.stop_index = 4'(k);
      it.stop_zoom = 16'(z);
      case ($urandom_range(0, 7))
        0: it.stop_value = 32'sh7FFF_FFFF;
        1: it.stop_value = 32'sh8000_0000;
        2: it.stop_value = 32'($urandom_range(0, 2000)) <<< 16;
        default: ;
      endcase
      send_item(it, 1'b0, '0);
      span = (65535 - z) / (NSTOPS - k);
      z = z + (($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, span));
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    if (out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        e = expected_q.pop_front();
        if (out_data_o.result_value !== e.result_value)
          report_mismatch($sformatf("result_value %h, expected %h",
                                    out_data_o.result_value, e.result_value));
        if (out_data_o.position !== e.position)
          report_mismatch($sformatf("position %0d, expected %0d",
                                    out_data_o.position, e.position));
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 700;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(0, 99) < 10);
    end
  end

  initial begin
    dir_row_t row;
    in_item_t it;
    logic [4:0]  cnt_set [10] = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd5, 5'd16, 5'd1, 5'd9, 5'd16, 5'd3};
    logic [15:0] base_set [10] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h1000, 16'hF000,
                                   16'h0001, 16'hFFFF, 16'h0000, 16'h0000, 16'h3000};
    logic [63:0] g;

    g = 64'd1 << 29;
    root_step[0] = g;
    for (int k = 1; k <= 23; k++) begin
      g = floor_sqrt(g << 30);
      root_step[k] = g;
    end

    // directed: fill every stop, then queries under the reset config (two stops, linear)
    for (int k = 0; k < NSTOPS; k++) begin
      row.item = '0;
      row.item.operation = OP_WRITE;
      row.item.stop_index = 4'(k);
      row.item.stop_zoom = 16'(k * 2048);
      row.item.stop_value = 32'(k * 65536 - 500000);
      row.typed = 1'b0;
      row.result = '0;
      if (k == 0) row.item.stop_value = 32'sh8000_0000;
      if (k == 1) row.item.stop_value = 32'sh7FFF_FFFF;
      if (k == 15) row.item.stop_zoom = 16'hFFFF;
      dir_tab.insert(dir_tab.size(), row);
    end
    row.item = '0;
    row.item.operation = OP_QUERY;
    row.typed = 1'b1;
    row.item.query_zoom = 16'h0000;
    row.result = '{result_value: 32'sh8000_0000, position: POS_FIRST};
    dir_tab.insert(dir_tab.size(), row);
    row.item.query_zoom = 16'hFFFF;
    row.result = '{result_value: 32'sh7FFF_FFFF, position: POS_BEYOND};
    dir_tab.insert(dir_tab.size(), row);
    row.item.query_zoom = 16'd2048;
    dir_tab.insert(dir_tab.size(), row);
    row.typed = 1'b0;
    row.item.query_zoom = 16'd1;
    dir_tab.insert(dir_tab.size(), row);
    row.item.query_zoom = 16'd1024;
    dir_tab.insert(dir_tab.size(), row);
    row.item.query_zoom = 16'd2047;
    dir_tab.insert(dir_tab.size(), row);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].result);

    for (int ph = 0; ph < 10; ph++) begin
      drain_results();
      write_reg(REG_STOP_COUNT, 16'(cnt_set[ph]));
      write_reg(REG_LOG2_BASE, (ph == 8) ? 16'($urandom) : base_set[ph]);
      calm = (ph == 2);
      if (ph == 4) hold_req++;
      load_sorted_table();
      for (int j = 0; j < 40; j++) begin
        if (ph == 6 && j == 20) drain_results();
        it = rand_item(($urandom_range(0, 99) < 80) ? OP_QUERY : OP_WRITE);
        // queries mostly land inside the populated span
        if (it.operation == OP_QUERY && $urandom_range(0, 3) != 0)
          it.query_zoom = 16'($urandom_range(int'(zoom_tab[0]), int'(zoom_tab[NSTOPS-1])));
        send_item(it, 1'b0, '0);
      end
      if (ph == 7) load_sorted_table();
    end

    drain_results();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
